// File: rtl/core/ps2_mouse_cursor_tracker_defines.svh
// Assertion macros shared by the RTL of the cursor tracker.
// Each check is clocked on clk and switched off while rst is high.
`ifndef PS2_MOUSE_CURSOR_TRACKER_DEFINES_SVH
`define PS2_MOUSE_CURSOR_TRACKER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Condition that must hold at every clock edge
`define PMCT_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("pmct check failed");

// Consequent that must hold in the cycle after the antecedent
`define PMCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pmct check failed");

`else

`define PMCT_ASSERT_ALWAYS(lbl, cond)
`define PMCT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/core/pmct_pkg.sv
`timescale 1ns / 1ps

package pmct_pkg;

  // Field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SIZE_W = 11;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned SUM_W  = 12;

  // Special byte and status bit positions
  localparam logic [BYTE_W-1:0] ACK_BYTE = 8'hFA;
  localparam int unsigned BTN_LEFT_BIT = 0;
  localparam int unsigned SIGN_X_BIT   = 4;
  localparam int unsigned SIGN_Y_BIT   = 5;
  localparam int unsigned OVF_X_BIT    = 6;
  localparam int unsigned OVF_Y_BIT    = 7;

  // Limits after reset (320 x 240 screen)
  localparam logic [POS_W-1:0] POS_MAX     = 10'd1023;
  localparam logic [POS_W-1:0] X_LIM_RESET = 10'd319;
  localparam logic [POS_W-1:0] Y_LIM_RESET = 10'd239;

  // Configuration register indexes
  typedef enum logic {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_index_t;

  // Position of the next byte within a packet
  typedef enum logic [1:0] {
    BI_STATUS = 2'd0,
    BI_MOVE_X = 2'd1,
    BI_MOVE_Y = 2'd2
  } byte_index_t;

  // Cursor limits handed to the decoder
  typedef struct packed {
    logic [POS_W-1:0] x_lim;
    logic [POS_W-1:0] y_lim;
  } pmct_limits_t;

  // One result item
  typedef struct packed {
    logic [POS_W-1:0] cursor_x;
    logic [POS_W-1:0] cursor_y;
    logic             left_click;
    logic             packet_end;
  } pmct_result_t;

  // Highest coordinate for a screen size: zero acts as one, saturate at 1023
  function automatic logic [POS_W-1:0] limit_of(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] m1;
    begin
      m1 = size - SIZE_W'(1);
      if (size == '0) begin
        limit_of = '0;
      end else if (m1 > SIZE_W'(POS_MAX)) begin
        limit_of = POS_MAX;
      end else begin
        limit_of = m1[POS_W-1:0];
      end
    end
  endfunction

endpackage

// File: rtl/core/pmct_cfg.sv
`timescale 1ns / 1ps

module pmct_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  pmct_pkg::cfg_index_t       cfg_index,
  input  logic [pmct_pkg::SIZE_W-1:0] cfg_data,
  output pmct_pkg::pmct_limits_t     limits
);
  import pmct_pkg::*;

  logic [POS_W-1:0] x_lim;
  logic [POS_W-1:0] y_lim;

  // Screen sizes are kept as their highest coordinate
  always_ff @(posedge clk) begin
    if (rst) begin
      x_lim <= X_LIM_RESET;
      y_lim <= Y_LIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  x_lim <= limit_of(cfg_data);
        CFG_SCREEN_HEIGHT: y_lim <= limit_of(cfg_data);
        default: ;
      endcase
    end
  end

  assign limits.x_lim = x_lim;
  assign limits.y_lim = y_lim;

endmodule

// File: rtl/core/pmct_decode.sv
`timescale 1ns / 1ps
`include "ps2_mouse_cursor_tracker_defines.svh"

module pmct_decode (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  logic [pmct_pkg::BYTE_W-1:0] rx_byte,
  input  pmct_pkg::pmct_limits_t      limits,
  output pmct_pkg::pmct_result_t      result
);
  import pmct_pkg::*;

  byte_index_t      byte_index;
  byte_index_t      byte_index_next;
  logic [BYTE_W-1:0] status_byte;
  logic [BYTE_W-1:0] status_byte_next;
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;

  logic              is_ack;
  logic [SUM_W-1:0]  sum_x;
  logic [SUM_W-1:0]  sum_y;
  logic [SUM_W-1:0]  x_val;
  logic [SUM_W-1:0]  y_val;
  logic [POS_W-1:0]  pos_x_next;
  logic [POS_W-1:0]  pos_y_next;
  logic              click;
  logic              done;

  // Clamp a signed coordinate to 0..lim
  function automatic logic [POS_W-1:0] clamp_pos(input logic [SUM_W-1:0] v,
                                                 input logic [POS_W-1:0] lim);
    begin
      if (v[SUM_W-1]) begin
        clamp_pos = '0;
      end else if (v[SUM_W-2:0] > (SUM_W-1)'(lim)) begin
        clamp_pos = lim;
      end else begin
        clamp_pos = v[POS_W-1:0];
      end
    end
  endfunction

  assign is_ack = (rx_byte == ACK_BYTE);

  // Packet position sequencing; an acknowledge restarts the packet
  always_comb begin
    byte_index_next = byte_index;
    if (is_ack) begin
      byte_index_next = BI_STATUS;
    end else begin
      unique case (byte_index)
        BI_MOVE_X: byte_index_next = BI_MOVE_Y;
        BI_MOVE_Y: byte_index_next = BI_STATUS;
        default:   byte_index_next = BI_MOVE_X;
      endcase
    end
  end

  // 9-bit moves {sign, byte}; y is subtracted so the screen counts down
  assign sum_x = {2'b00, pos_x} + {{(SUM_W-BYTE_W){status_byte[SIGN_X_BIT]}}, rx_byte};
  assign sum_y = {2'b00, pos_y} - {{(SUM_W-BYTE_W){status_byte[SIGN_Y_BIT]}}, rx_byte};

  // Per-byte outputs and data updates
  always_comb begin
    x_val            = {2'b00, pos_x};
    y_val            = {2'b00, pos_y};
    status_byte_next = status_byte;
    click            = 1'b0;
    done             = 1'b0;
    unique case (byte_index)
      BI_MOVE_X: begin
        if (!status_byte[OVF_X_BIT]) x_val = sum_x;
      end
      BI_MOVE_Y: begin
        if (!status_byte[OVF_Y_BIT]) y_val = sum_y;
        done = 1'b1;
      end
      default: begin
        status_byte_next = rx_byte;
        click            = rx_byte[BTN_LEFT_BIT];
      end
    endcase
    if (is_ack) begin
      pos_x_next = pos_x;
      pos_y_next = pos_y;
      status_byte_next = status_byte;
      click = 1'b0;
      done  = 1'b0;
    end else begin
      pos_x_next = clamp_pos(x_val, limits.x_lim);
      pos_y_next = clamp_pos(y_val, limits.y_lim);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= BI_STATUS;
      status_byte <= '0;
      pos_x       <= '0;
      pos_y       <= '0;
    end else if (take) begin
      byte_index  <= byte_index_next;
      status_byte <= status_byte_next;
      pos_x       <= pos_x_next;
      pos_y       <= pos_y_next;
    end
  end

  assign result.cursor_x   = pos_x_next;
  assign result.cursor_y   = pos_y_next;
  assign result.left_click = click;
  assign result.packet_end = done;

  // Checks
  `PMCT_ASSERT_ALWAYS(a_idx_legal, byte_index != 2'd3)
  `PMCT_ASSERT_NEXT(a_ack_holds_pos, take && is_ack,
                    $stable(pos_x) && $stable(pos_y) && byte_index == BI_STATUS)
  `PMCT_ASSERT_NEXT(a_end_restarts, take && done, byte_index == BI_STATUS)
  `PMCT_ASSERT_ALWAYS(a_click_on_status, !click || byte_index == BI_STATUS || byte_index == 2'd3)

endmodule

// File: rtl/core/ps2_mouse_cursor_tracker.sv
`timescale 1ns / 1ps
`include "ps2_mouse_cursor_tracker_defines.svh"

// PS/2 mouse cursor tracker. Takes one received mouse byte per cycle while in_ready is
// high and returns one result item per byte in the cycle after it is accepted: the
// clamped cursor, a left_click flag on status bytes and packet_end on the
// third byte of each packet. A 0xFA acknowledge restarts the packet and
// leaves the cursor alone. The decode, add and clamp sit between the state
// registers and a single result register; in_ready stays high while that
// register is empty or being taken, so bytes stream at one per cycle.
// Screen size registers (index 0 width, 1 height) reset to 320 x 240 and
// should be written only while no item is in flight.
module ps2_mouse_cursor_tracker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  pmct_pkg::cfg_index_t        cfg_index,
  input  logic [pmct_pkg::SIZE_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pmct_pkg::BYTE_W-1:0] rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pmct_pkg::POS_W-1:0]  cursor_x,
  output logic [pmct_pkg::POS_W-1:0]  cursor_y,
  output logic                        left_click,
  output logic                        packet_end
);
  import pmct_pkg::*;

  pmct_limits_t limits;
  pmct_result_t result_next;
  pmct_result_t result;
  logic         take;

  pmct_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .limits    (limits)
  );

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  pmct_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx_byte),
    .limits  (limits),
    .result  (result_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

  assign cursor_x   = result.cursor_x;
  assign cursor_y   = result.cursor_y;
  assign left_click = result.left_click;
  assign packet_end = result.packet_end;

  // Checks
  `PMCT_ASSERT_NEXT(a_take_fills, take, out_valid)
  `PMCT_ASSERT_ALWAYS(a_flags_exclusive, !(out_valid && left_click && packet_end))
  `PMCT_ASSERT_NEXT(a_held_result, out_valid && !out_ready,
                    out_valid && $stable(result))

endmodule

// File: dv/ps2_mouse_cursor_tracker_tb.sv
`timescale 1ns / 1ps

module ps2_mouse_cursor_tracker_tb;
  import pmct_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 150;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 58;

  // Cursor predictor and store of expected cursor items
  class cursor_scoreboard;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    byte_index_t       next_pos;
    logic [BYTE_W-1:0] status;
    logic [POS_W-1:0]  px;
    logic [POS_W-1:0]  py;
    pmct_result_t      expected_cursor[$];
    int failures, n_bytes, n_acks, n_packets, n_clicks, n_checked;

    function new();
      width    = 11'd320;
      height   = 11'd240;
      next_pos = BI_STATUS;
      status   = '0;
      px       = '0;
      py       = '0;
      failures = 0;
      n_bytes  = 0;
      n_acks   = 0;
      n_packets = 0;
      n_clicks = 0;
      n_checked = 0;
    endfunction

    function void set_screen(cfg_index_t idx, logic [SIZE_W-1:0] v);
      if (idx == CFG_SCREEN_WIDTH) width = v;
      else height = v;
    endfunction

    // Zero size pins the axis at 0; anything past 1024 saturates at 1023
    function logic [POS_W-1:0] clamp_to(int v, logic [SIZE_W-1:0] size);
      int top;
      top = (size == 0) ? 0 : (size > 1024) ? 1023 : int'(size) - 1;
      if (v < 0) return '0;
      if (v > top) v = top;
      return POS_W'(v);
    endfunction

    // Work out the cursor item that an accepted byte should produce
    function void note_byte(logic [BYTE_W-1:0] b);
      pmct_result_t r;
      int x, y, mv;
      r = '0;
      n_bytes++;
      if (b == ACK_BYTE) begin
        next_pos = BI_STATUS;
        n_acks++;
      end else begin
        x = int'(px);
        y = int'(py);
        case (next_pos)
          BI_MOVE_X: begin
            if (!status[OVF_X_BIT]) begin
              mv = status[SIGN_X_BIT] ? int'(b) - 256 : int'(b);
              x += mv;
            end
            next_pos = BI_MOVE_Y;
          end
          BI_MOVE_Y: begin
            if (!status[OVF_Y_BIT]) begin
              mv = status[SIGN_Y_BIT] ? int'(b) - 256 : int'(b);
              y -= mv;
            end
            r.packet_end = 1'b1;
            n_packets++;
            next_pos = BI_STATUS;
          end
          default: begin
            status = b;
            r.left_click = b[BTN_LEFT_BIT];
            if (b[BTN_LEFT_BIT]) n_clicks++;
            next_pos = BI_MOVE_X;
          end
        endcase
        px = clamp_to(x, width);
        py = clamp_to(y, height);
      end
      r.cursor_x = px;
      r.cursor_y = py;
      expected_cursor.push_back(r);
    endfunction

    function void check_result(pmct_result_t got);
      pmct_result_t want;
      if (expected_cursor.size() == 0) begin
        $display("%0t: unexpected item x=%0d y=%0d click=%0b end=%0b", $time,
                 got.cursor_x, got.cursor_y, got.left_click, got.packet_end);
        failures++;
        return;
      end
      want = expected_cursor.pop_front();
      n_checked++;
      if (got.cursor_x !== want.cursor_x) begin
        $display("%0t: cursor_x expected %0d, got %0d", $time, want.cursor_x, got.cursor_x);
        failures++;
      end
      if (got.cursor_y !== want.cursor_y) begin
        $display("%0t: cursor_y expected %0d, got %0d", $time, want.cursor_y, got.cursor_y);
        failures++;
      end
      if (got.left_click !== want.left_click) begin
        $display("%0t: left_click expected %0b, got %0b", $time,
                 want.left_click, got.left_click);
        failures++;
      end
      if (got.packet_end !== want.packet_end) begin
        $display("%0t: packet_end expected %0b, got %0b", $time,
                 want.packet_end, got.packet_end);
        failures++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst       = 1'b1;
  logic              cfg_we    = 1'b0;
  cfg_index_t        cfg_index = CFG_SCREEN_WIDTH;
  logic [SIZE_W-1:0] cfg_data  = '0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] rx_byte   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [POS_W-1:0]  cursor_x;
  logic [POS_W-1:0]  cursor_y;
  logic              left_click;
  logic              packet_end;

  cursor_scoreboard sb;
  int  cycle_count   = 0;
  int  burst_left    = 0;
  bit  long_hold_req = 1'b0;

  ps2_mouse_cursor_tracker u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cursor_x   (cursor_x),
    .cursor_y   (cursor_y),
    .left_click (left_click),
    .packet_end (packet_end)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Cycle count and run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    pmct_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.cursor_x   = cursor_x;
      got.cursor_y   = cursor_y;
      got.left_click = left_click;
      got.packet_end = packet_end;
      sb.check_result(got);
    end
  end

  // Receiver: stall patterns that change at random, plus a long hold on request
  initial begin : receiver
    int mode, span, tick;
    mode = 0;
    span = 0;
    tick = 0;
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 4);
          span = $urandom_range(4, 60);
        end
        span--;
        tick++;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) != 0);
          3: out_ready <= (tick % 3 != 0);
          default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Offer one byte, with bursts and gaps, and note it once accepted
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
  endtask

  // Stop offering and wait until every expected item has come back
  task automatic drain;
    in_valid <= 1'b0;
    while (sb.expected_cursor.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_screen(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SCREEN_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_SCREEN_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_screen(CFG_SCREEN_WIDTH, w);
    sb.set_screen(CFG_SCREEN_HEIGHT, h);
  endtask

  // Any byte but the acknowledge
  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom); while (b == ACK_BYTE);
    return b;
  endfunction

  // Status byte, overflow bits mostly clear so that moves land
  function automatic logic [BYTE_W-1:0] status_of_packet();
    logic [BYTE_W-1:0] b;
    b = plain_byte();
    if ($urandom_range(0, 9) < 7) begin
      b[OVF_X_BIT] = 1'b0;
      b[OVF_Y_BIT] = 1'b0;
    end
    return b;
  endfunction

  // Mostly whole packets, some cut short by an acknowledge, some loose bytes
  task automatic send_mouse_traffic(input int n);
    int sent, pick;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        send_byte(status_of_packet());
        send_byte(plain_byte());
        send_byte(plain_byte());
        sent += 3;
      end else if (pick < 87) begin
        send_byte(status_of_packet());
        if ($urandom_range(0, 1)) begin
          send_byte(plain_byte());
          sent++;
        end
        send_byte(ACK_BYTE);
        sent += 2;
      end else begin
        send_byte(($urandom_range(0, 4) == 0) ? ACK_BYTE : BYTE_W'($urandom));
        sent++;
      end
    end
  endtask

  logic [BYTE_W-1:0] directed_bytes[25] = '{
    8'h21, 8'h64, 8'h9C,  // left click, x +100, y up by -100
    8'h10, 8'h00, 8'hFF,  // x -256 clamps at 0, y -255 clamps at 0
    8'h00, 8'hFF, 8'h00,  // x +255
    8'h00, 8'hFF, 8'h00,  // x saturates at right edge
    8'h20, 8'h00, 8'h00,  // y +256 saturates at bottom edge
    8'hC1, 8'h7F, 8'h80,  // both overflow bits: moves skipped
    8'h30, 8'hFF, 8'hFF,  // both signs set: -1 each way
    8'h08, 8'hFA,         // acknowledge in mid packet
    8'hFA,                // acknowledge where a status byte is due
    8'h01                 // restart with a click
  };

  int phase_width[PHASES]  = '{1024, 1, 0, 2047, 1025, 640, 320, 0, 0};
  int phase_height[PHASES] = '{1024, 1, 0, 1500, 2, 480, 240, 0, 0};

  // Main sequence
  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed bytes on the reset screen size
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    drain();

    // Random traffic across a range of screen sizes
    for (int p = 0; p < PHASES; p++) begin
      if (p >= 7) begin
        phase_width[p]  = $urandom_range(1, 1024);
        phase_height[p] = $urandom_range(1, 1024);
      end
      write_screen(SIZE_W'(phase_width[p]), SIZE_W'(phase_height[p]));
      // Hold the receiver off while bytes keep coming so the block backs up
      if (p == 5) long_hold_req = 1'b1;
      send_mouse_traffic(PHASE_ITEMS);
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Covered %0d bytes: %0d packets, %0d clicks, %0d acknowledges, %0d screen sizes",
             sb.n_bytes, sb.n_packets, sb.n_clicks, sb.n_acks, PHASES + 1);
    $display("%0d items checked, %0d mismatches", sb.n_checked, sb.failures);
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
